// File: rtl/core/rpu_pkg.sv
// Package for the RMSprop parameter update block.
// Holds register reset values, the register index codes and the default fraction width.
package rpu_pkg;

  localparam int DefFracBits = 24;

  // register widths of the configuration file
  localparam int LrW   = 25;
  localparam int DecW  = 25;
  localparam int ClipW = 31;
  localparam int EpsW  = 25;

  localparam logic [LrW-1:0]   LrReset   = 25'd33554;
  localparam logic [DecW-1:0]  DecReset  = 25'd15938355;
  localparam logic [ClipW-1:0] ClipReset = 31'd83886080;
  localparam logic [EpsW-1:0]  EpsReset  = 25'd1;

  // dividend width of the update quotient: |lr*g| stays below 2^56
  localparam int DivW = 56;

  typedef enum logic [1:0] {
    REG_LEARN_RATE = 2'd0,
    REG_DECAY      = 2'd1,
    REG_CLIP_LIMIT = 2'd2,
    REG_EPSILON    = 2'd3
  } cfg_idx_t;

  // pipeline control handed between stages
  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

endpackage

// File: rtl/core/rpu_front.sv
// Front stages: gradient clip, squares and products, memory update and numerator.
// Depends on rpu_pkg for widths and the control struct.
module rpu_front #(
  parameter int FRAC_BITS = rpu_pkg::DefFracBits
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rpu_pkg::pipe_ctl_t        ctl_in,
  input  logic signed [31:0]        weight_in,
  input  logic [30:0]               memory_in,
  input  logic signed [31:0]        gradient,
  input  logic [rpu_pkg::LrW-1:0]   learn_rate,
  input  logic [rpu_pkg::DecW-1:0]  decay,
  input  logic [rpu_pkg::ClipW-1:0] clip_limit,
  output logic                      valid_out,
  output logic signed [31:0]        weight_out,
  output logic [30:0]               memory_out,
  output logic [55-FRAC_BITS:0]     num_mag,
  output logic                      num_neg
);
  import rpu_pkg::*;

  localparam int SqW = 62 - FRAC_BITS;
  localparam int T2W = SqW + 32;
  localparam logic [31:0] One = 32'(64'd1 << FRAC_BITS);

  // stage A registers
  logic               a_v_r, a_v_nxt;
  logic signed [31:0] a_w_r, a_g_r, a_g_nxt;
  logic [30:0]        a_mem_r, a_ag_r, a_ag_nxt;
  logic [31:0]        a_d_r, a_d_nxt;
  // stage B registers
  logic               b_v_r;
  logic signed [31:0] b_w_r;
  logic [SqW-1:0]     b_sq_r;
  logic [30:0]        b_dm_r;
  logic [31:0]        b_omd_r;
  logic signed [56:0] b_p_r;
  // stage C registers
  logic               c_v_r;
  logic signed [31:0] c_w_r;
  logic [30:0]        c_m_r, c_m_nxt;
  logic [55-FRAC_BITS:0] c_an_r, c_an_nxt;
  logic               c_neg_r, c_neg_nxt;

  logic signed [31:0] lim;
  logic [31:0]        dec32;
  logic [61:0]        sqp;
  logic [62:0]        dmp;
  logic signed [56:0] p_nxt;
  logic [T2W-1:0]     t2p;
  logic [63:0]        msum;
  logic signed [56:0] num, nabs;

  // clip the gradient and bound the decay
  always_comb begin
    lim   = $signed({1'b0, clip_limit});
    dec32 = 32'(decay);
    if (gradient > lim) begin
      a_g_nxt = lim;
    end else if (gradient < -lim) begin
      a_g_nxt = -lim;
    end else begin
      a_g_nxt = gradient;
    end
    a_ag_nxt = a_g_nxt[31] ? 31'(-a_g_nxt) : a_g_nxt[30:0];
    a_d_nxt  = (dec32 > One) ? One : dec32;
    a_v_nxt  = ctl_in.valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (ctl_in.en) begin
      a_v_r <= a_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.en) begin
      a_w_r   <= weight_in;
      a_mem_r <= memory_in;
      a_g_r   <= a_g_nxt;
      a_ag_r  <= a_ag_nxt;
      a_d_r   <= a_d_nxt;
    end
  end

  // square the gradient, scale the old memory, form lr*g
  always_comb begin
    sqp   = 62'(a_ag_r) * 62'(a_ag_r);
    dmp   = 63'(a_d_r) * 63'(a_mem_r);
    p_nxt = $signed({32'b0, learn_rate}) * $signed({{25{a_g_r[31]}}, a_g_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (ctl_in.en) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.en) begin
      b_w_r   <= a_w_r;
      b_sq_r  <= sqp[61:FRAC_BITS];
      b_dm_r  <= dmp[FRAC_BITS+30:FRAC_BITS];
      b_omd_r <= One - a_d_r;
      b_p_r   <= p_nxt;
    end
  end

  // add the new term, saturate the memory, floor the numerator
  always_comb begin
    t2p  = T2W'(b_omd_r) * T2W'(b_sq_r);
    msum = 64'(b_dm_r) + 64'(t2p[61:FRAC_BITS]);
    c_m_nxt = (msum > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : msum[30:0];
    num  = b_p_r >>> FRAC_BITS;
    nabs = num[56] ? -num : num;
    c_an_nxt  = nabs[55-FRAC_BITS:0];
    c_neg_nxt = num[56];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (ctl_in.en) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.en) begin
      c_w_r   <= b_w_r;
      c_m_r   <= c_m_nxt;
      c_an_r  <= c_an_nxt;
      c_neg_r <= c_neg_nxt;
    end
  end

  assign valid_out  = c_v_r;
  assign weight_out = c_w_r;
  assign memory_out = c_m_r;
  assign num_mag    = c_an_r;
  assign num_neg    = c_neg_r;

endmodule

// File: rtl/core/rpu_sqrt_cell.sv
// One cell of the square root row: settles one root bit from two radicand bits.
// Depends on rpu_pkg for the control struct.
module rpu_sqrt_cell #(
  parameter int RW = 28,
  parameter int PW = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rpu_pkg::pipe_ctl_t ctl_in,
  input  logic [RW+1:0]      rem_in,
  input  logic [RW-1:0]      root_in,
  input  logic [2*RW-1:0]    rad_in,
  input  logic [PW-1:0]      pl_in,
  output logic               valid_out,
  output logic [RW+1:0]      rem_out,
  output logic [RW-1:0]      root_out,
  output logic [2*RW-1:0]    rad_out,
  output logic [PW-1:0]      pl_out
);
  import rpu_pkg::*;

  logic            v_r;
  logic [RW+1:0]   rem_r, rem_nxt, rem_sh, trial;
  logic [RW-1:0]   root_r, root_nxt;
  logic [2*RW-1:0] rad_r;
  logic [PW-1:0]   pl_r;

  // bring down two bits and try the next root bit
  always_comb begin
    rem_sh = {rem_in[RW-1:0], rad_in[2*RW-1:2*RW-2]};
    trial  = {root_in, 2'b01};
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {root_in[RW-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {root_in[RW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ctl_in.en) begin
      v_r <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      rad_r  <= {rad_in[2*RW-3:0], 2'b00};
      pl_r   <= pl_in;
    end
  end

  assign valid_out = v_r;
  assign rem_out   = rem_r;
  assign root_out  = root_r;
  assign rad_out   = rad_r;
  assign pl_out    = pl_r;

endmodule

// File: rtl/core/rpu_div_cell.sv
// One cell of the divider row: restoring step that settles one quotient bit.
// Depends on rpu_pkg for the control struct.
module rpu_div_cell #(
  parameter int RW = 28,
  parameter int DW = 56,
  parameter int PW = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rpu_pkg::pipe_ctl_t ctl_in,
  input  logic [RW-1:0]      rem_in,
  input  logic [RW-1:0]      dvs_in,
  input  logic [DW-1:0]      dq_in,
  input  logic [PW-1:0]      pl_in,
  output logic               valid_out,
  output logic [RW-1:0]      rem_out,
  output logic [RW-1:0]      dvs_out,
  output logic [DW-1:0]      dq_out,
  output logic [PW-1:0]      pl_out
);
  import rpu_pkg::*;

  logic          v_r;
  logic [RW-1:0] rem_r, dvs_r, rem_nxt;
  logic [RW:0]   rem_sh;
  logic [DW-1:0] dq_r;
  logic [PW-1:0] pl_r;
  logic          qbit;

  // shift in the next dividend bit and subtract where it fits
  always_comb begin
    rem_sh = {rem_in, dq_in[DW-1]};
    qbit   = (rem_sh >= {1'b0, dvs_in});
    rem_nxt = qbit ? RW'(rem_sh - {1'b0, dvs_in}) : rem_sh[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ctl_in.en) begin
      v_r <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.en) begin
      rem_r <= rem_nxt;
      dvs_r <= dvs_in;
      dq_r  <= {dq_in[DW-2:0], qbit};
      pl_r  <= pl_in;
    end
  end

  assign valid_out = v_r;
  assign rem_out   = rem_r;
  assign dvs_out   = dvs_r;
  assign dq_out    = dq_r;
  assign pl_out    = pl_r;

endmodule

// File: rtl/core/rmsprop_param_update_top.sv
// Top level of the RMSprop parameter update: config registers, front stages,
// square root and divider cell rows, and the output register. Uses rpu_pkg.
//
// One element enters per clock cycle and one result leaves per cycle unless out_tready
// stalls the pipe. The path runs through the front stages, the square root row of RW
// cells, RW = (FRAC_BITS + 33) / 2 root bits, the divider row of 56 cells and the
// output register. The whole pipe advances together whenever the output
// register is empty or being taken, so a stall on out_tready holds every stage.
// Registers: 0 learn_rate, 1 decay, 2 clip_limit, 3 epsilon; cfg_ready is always high.
module rmsprop_param_update_top #(
  parameter int FRAC_BITS = rpu_pkg::DefFracBits
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // weight_in[31:0], memory_in[62:32], gradient[94:63]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // weight_out[31:0], memory_out[62:32]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import rpu_pkg::*;

  localparam int RW  = (FRAC_BITS + 33) / 2;
  localparam int SW  = 2 * RW;
  localparam int AW  = 56 - FRAC_BITS;
  localparam int SPW = 32 + 1 + AW + 31;
  localparam int DPW = 32 + 1 + 31;

  logic [LrW-1:0]   lr_r;
  logic [DecW-1:0]  dec_r;
  logic [ClipW-1:0] clip_r;
  logic [EpsW-1:0]  eps_r;
  cfg_idx_t         cfg_sel;

  logic      adv;
  pipe_ctl_t fctl, sctl [RW], dctl [DivW];

  logic               f_v;
  logic signed [31:0] f_w;
  logic [30:0]        f_m;
  logic [AW-1:0]      f_an;
  logic               f_neg;

  logic            s_v   [RW+1];
  logic [RW+1:0]   s_rem [RW+1];
  logic [RW-1:0]   s_root[RW+1];
  logic [SW-1:0]   s_rad [RW+1];
  logic [SPW-1:0]  s_pl  [RW+1];

  logic            d_v   [DivW+1];
  logic [RW-1:0]   d_rem [DivW+1];
  logic [RW-1:0]   d_dvs [DivW+1];
  logic [DivW-1:0] d_dq  [DivW+1];
  logic [DPW-1:0]  d_pl  [DivW+1];

  logic [31:0]        radv;
  logic [RW-1:0]      root_s;
  logic [AW-1:0]      an_s;
  logic signed [31:0] wq;
  logic               negq;
  logic [30:0]        mq;
  logic signed [57:0] qs, nw;
  logic signed [31:0] nw_nxt;

  logic        ov_r;
  logic [31:0] ow_r;
  logic [30:0] om_r;

  // write configuration registers
  assign cfg_ready = 1'b1;
  assign cfg_sel   = cfg_idx_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r   <= LrReset;
      dec_r  <= DecReset;
      clip_r <= ClipReset;
      eps_r  <= EpsReset;
    end else if (cfg_valid) begin
      unique case (cfg_sel)
        REG_LEARN_RATE: lr_r   <= cfg_data[LrW-1:0];
        REG_DECAY:      dec_r  <= cfg_data[DecW-1:0];
        REG_CLIP_LIMIT: clip_r <= cfg_data[ClipW-1:0];
        REG_EPSILON:    eps_r  <= cfg_data[EpsW-1:0];
        default:        lr_r   <= lr_r;
      endcase
    end
  end

  // advance the whole pipe when the output slot is free or draining
  assign adv       = out_tready | ~ov_r;
  assign in_tready = adv;
  assign fctl      = '{en: adv, valid: in_tvalid};

  rpu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_in     (fctl),
    .weight_in  (in_tdata[31:0]),
    .memory_in  (in_tdata[62:32]),
    .gradient   (in_tdata[94:63]),
    .learn_rate (lr_r),
    .decay      (dec_r),
    .clip_limit (clip_r),
    .valid_out  (f_v),
    .weight_out (f_w),
    .memory_out (f_m),
    .num_mag    (f_an),
    .num_neg    (f_neg)
  );

  // feed the root row with (m + epsilon) scaled by one
  assign radv      = 32'(f_m) + 32'(eps_r);
  assign s_v[0]    = f_v;
  assign s_rem[0]  = '0;
  assign s_root[0] = '0;
  assign s_rad[0]  = SW'({radv, {FRAC_BITS{1'b0}}});
  assign s_pl[0]   = {f_w, f_neg, f_an, f_m};

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    assign sctl[i] = '{en: adv, valid: s_v[i]};
    rpu_sqrt_cell #(.RW(RW), .PW(SPW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl_in    (sctl[i]),
      .rem_in    (s_rem[i]),
      .root_in   (s_root[i]),
      .rad_in    (s_rad[i]),
      .pl_in     (s_pl[i]),
      .valid_out (s_v[i+1]),
      .rem_out   (s_rem[i+1]),
      .root_out  (s_root[i+1]),
      .rad_out   (s_rad[i+1]),
      .pl_out    (s_pl[i+1])
    );
  end

  // hand the root to the divider, a zero root divides by one
  assign root_s   = (s_root[RW] == '0) ? RW'(1) : s_root[RW];
  assign an_s     = s_pl[RW][AW+30:31];
  assign d_v[0]   = s_v[RW];
  assign d_rem[0] = '0;
  assign d_dvs[0] = root_s;
  assign d_dq[0]  = {an_s, {FRAC_BITS{1'b0}}};
  assign d_pl[0]  = {s_pl[RW][SPW-1:SPW-33], s_pl[RW][30:0]};

  for (genvar j = 0; j < DivW; j++) begin : g_div
    assign dctl[j] = '{en: adv, valid: d_v[j]};
    rpu_div_cell #(.RW(RW), .DW(DivW), .PW(DPW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl_in    (dctl[j]),
      .rem_in    (d_rem[j]),
      .dvs_in    (d_dvs[j]),
      .dq_in     (d_dq[j]),
      .pl_in     (d_pl[j]),
      .valid_out (d_v[j+1]),
      .rem_out   (d_rem[j+1]),
      .dvs_out   (d_dvs[j+1]),
      .dq_out    (d_dq[j+1]),
      .pl_out    (d_pl[j+1])
    );
  end

  // subtract the signed step and saturate the weight
  always_comb begin
    wq   = $signed(d_pl[DivW][63:32]);
    negq = d_pl[DivW][31];
    mq   = d_pl[DivW][30:0];
    qs   = negq ? -$signed({2'b00, d_dq[DivW]}) : $signed({2'b00, d_dq[DivW]});
    nw   = 58'(wq) - qs;
    if (nw > 58'sd2147483647) begin
      nw_nxt = 32'sh7FFF_FFFF;
    end else if (nw < -58'sd2147483648) begin
      nw_nxt = 32'sh8000_0000;
    end else begin
      nw_nxt = nw[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= d_v[DivW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ow_r <= nw_nxt;
      om_r <= mq;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {1'b0, om_r, ow_r};

endmodule

// File: tb/rmsprop_param_update_top_tb.sv
// Testbench for the RMSprop parameter update block rmsprop_param_update_top.
// Streams weight, memory and gradient elements and checks each update against
// a fixed-point model held in a scoreboard class; needs rpu_pkg.
`timescale 1ns / 100ps

module rmsprop_param_update_top_tb;
  import rpu_pkg::*;

  localparam int FracBits = DefFracBits;
  localparam longint One  = 64'sd1 << FracBits;
  localparam int Latency  = 3 + (FracBits + 33) / 2 + 56 + 1;
  localparam int WdogLimit = 20000;

  typedef struct packed {
    logic signed [31:0] weight;
    logic [30:0]        memory;
  } update_t;

  // Expected-update store and fixed-point model of the block
  class update_scoreboard;
    longint unsigned lr, dec, clip, eps;
    update_t pending[$];
    int      errors;
    int      checked;

    function new();
      lr = 64'(LrReset); dec = 64'(DecReset); clip = 64'(ClipReset); eps = 64'(EpsReset);
      errors = 0; checked = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_LEARN_RATE: lr   = 64'(val[24:0]);
        REG_DECAY:      dec  = 64'(val[24:0]);
        REG_CLIP_LIMIT: clip = 64'(val[30:0]);
        REG_EPSILON:    eps  = 64'(val[24:0]);
        default: ;
      endcase
    endfunction

    static function longint unsigned int_root(longint unsigned x);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    // floor of p / 2^FracBits for signed p
    static function longint floor_frac(longint p);
      return p >>> FracBits;
    endfunction

    function void note_element(logic [95:0] d);
      longint g, lim, num, q, nw, w;
      longint unsigned ag, sq, dd, mem, mnew, root, an, aq;
      update_t u;
      w   = longint'($signed(d[31:0]));
      mem = 64'(d[62:32]);
      g   = longint'($signed(d[94:63]));
      lim = longint'(clip);
      dd  = (dec > One) ? One : dec;
      if (g > lim) g = lim;
      if (g < -lim) g = -lim;
      ag = (g < 0) ? -g : g;
      sq = (ag * ag) >> FracBits;
      mnew = ((dd * mem) >> FracBits) + (((One - dd) * sq) >> FracBits);
      if (mnew > 64'h7FFF_FFFF) mnew = 64'h7FFF_FFFF;
      root = int_root((mnew + eps) << FracBits);
      if (root == 0) root = 1;
      num = floor_frac(longint'(lr) * g);
      an  = (num < 0) ? -num : num;
      aq  = (an << FracBits) / root;
      q   = (num < 0) ? -longint'(aq) : longint'(aq);
      nw  = w - q;
      if (nw > 64'sd2147483647) nw = 64'sd2147483647;
      if (nw < -64'sd2147483648) nw = -64'sd2147483648;
      u.weight = nw[31:0];
      u.memory = mnew[30:0];
      pending.push_back(u);
    endfunction

    function void check_update(logic [63:0] d);
      update_t e;
      if (pending.size() == 0) begin
        report("update with none expected", 64'sd0, longint'(d[31:0]));
        return;
      end
      e = pending.pop_front();
      checked++;
      if (d[31:0] !== e.weight)
        report("weight_out", longint'(e.weight), longint'(d[31:0]));
      if (d[62:32] !== e.memory)
        report("memory_out", longint'(e.memory), longint'(d[62:32]));
    endfunction

    function void report(string what, longint exp_v, longint got_v);
      errors++;
      $display("MISMATCH %s: expected %0h got %0h at %0t", what, exp_v, got_v, $time);
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_tvalid, in_tready;
  logic [95:0] in_tdata;
  logic        out_tvalid, out_tready;
  logic [63:0] out_tdata;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  update_scoreboard sb;
  int  idle_cycles;

  rmsprop_param_update_top u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: count cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WdogLimit) begin
      $display("Watchdog expired");
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: check every transaction, stall at random
  initial begin
    int wait_n;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (wait_n > 0) begin
        out_tready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk iff out_tvalid);
      sb.check_update(out_tdata);
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk iff cfg_ready);
    sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_element(logic signed [31:0] w, logic [30:0] m, logic signed [31:0] g,
                              bit gaps);
    int wait_n;
    wait_n = gaps ? $urandom_range(0, 13) : 0;
    if (wait_n > 0) begin
      in_tvalid <= 1'b0;
      repeat (wait_n) @(posedge clk);
    end
    in_tdata  <= {1'b0, g, m, w};
    in_tvalid <= 1'b1;
    @(posedge clk iff in_tready);
    sb.note_element({1'b0, g, m, w});
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_grad();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0FFF_FFFF);
      2: return -$urandom_range(0, 32'h0FFF_FFFF);
      default: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
    endcase
  endfunction

  initial begin
    bit gaps;
    sb = new();
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0;
    cfg_valid = 1'b0; cfg_index = REG_LEARN_RATE; cfg_data = '0;
    idle_cycles = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes and clipping at reset settings
    send_element(32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'sh8000_0000, 1'b0);
    send_element(32'sh8000_0000, 31'h0, 32'sh7FFF_FFFF, 1'b0);
    send_element(32'sh0, 31'h0, 32'sh0, 1'b0);
    send_element(32'sh8000_0000, 31'h0, 32'sh0500_0000, 1'b0);
    send_element(32'sh7FFF_FFFF, 31'h0, -32'sh0500_0001, 1'b0);
    send_element(32'sh0100_0000, 31'h0100_0000, -32'sh1, 1'b0);
    send_element(32'shFFFF_FFFF, 31'h5555_5555, 32'sh1, 1'b0);
    drain();

    // Extreme settings: decay above one and zero, largest learning rate, zero and maximum clip
    write_reg(REG_DECAY, 32'h01FF_FFFF);
    write_reg(REG_LEARN_RATE, 32'h0100_0000);
    write_reg(REG_CLIP_LIMIT, 32'h7FFF_FFFF);
    write_reg(REG_EPSILON, 32'h0100_0000);
    send_element(32'sh8000_0000, 31'h0, 32'sh8000_0000, 1'b0);
    send_element(32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
    drain();
    write_reg(REG_DECAY, 32'h0);
    write_reg(REG_LEARN_RATE, 32'h01FF_FFFF);
    write_reg(REG_CLIP_LIMIT, 32'h0);
    write_reg(REG_EPSILON, 32'h1);
    send_element(32'sh1234_5678, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
    drain();
    write_reg(REG_CLIP_LIMIT, 32'h7FFF_FFFF);
    send_element(32'sh0, 31'h0, 32'sh8000_0000, 1'b0);
    send_element(32'sh0, 31'h0, 32'sh7FFF_FFFF, 1'b0);
    send_element(32'sh0, 31'h7FFF_FFFF, -32'sh1, 1'b0);
    drain();

    // Random phases, each under its own settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_LEARN_RATE, $urandom_range(0, 25'h1FF_FFFF));
      write_reg(REG_DECAY, (ph == 0) ? 32'h0100_0000 : $urandom_range(0, 25'h1FF_FFFF));
      write_reg(REG_CLIP_LIMIT, (ph == 1) ? 32'h7FFF_FFFF : $urandom_range(0, 31'h7FFF_FFFF));
      write_reg(REG_EPSILON, $urandom_range(1, 25'h1FF_FFFF));
      for (int i = 0; i < 120; i++) begin
        gaps = (ph != 2);
        send_element($urandom, 31'($urandom_range(0, 31'h7FFF_FFFF) >> $urandom_range(0, 30)),
                     rand_grad(), gaps);
        // hold the sender once until the pipe has emptied
        if (ph == 3 && i == 60) begin
          in_tvalid <= 1'b0;
          while (sb.pending.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    $display("Covered %0d updates over many register settings, including decay above one,",
             sb.checked);
    $display("zero and full clip limits, gradient clipping and weight saturation.");
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/rpu_pkg.sv
rtl/core/rpu_front.sv
rtl/core/rpu_sqrt_cell.sv
rtl/core/rpu_div_cell.sv
rtl/core/rmsprop_param_update_top.sv
tb/rmsprop_param_update_top_tb.sv
